### src/bbcw_pkg.sv
// Shared types and constants for the box blur window unit.
package bbcw_pkg;

  localparam int PIX_W   = 24;
  localparam int POS_W   = 9;
  localparam int CRD_W   = 14;
  localparam int SUM_W   = 20;
  localparam int NUM_W   = SUM_W + 1;
  localparam int DEN_W   = 13;
  localparam int Q_W     = 8;
  localparam int QDEPTH  = 2;

  localparam logic [2:0] REG_IMG_W = 3'd0;
  localparam logic [2:0] REG_IMG_H = 3'd1;
  localparam logic [2:0] REG_WIN_W = 3'd2;
  localparam logic [2:0] REG_WIN_H = 3'd3;

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef struct packed {
    logic             op;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [PIX_W-1:0] pix;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic [9:0] img_w;
    logic [9:0] img_h;
    logic [4:0] win_w;
    logic [4:0] win_h;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

### src/bbcw_front.sv
// Front end: accepts requests into a two-entry queue and tags them by opcode.
module bbcw_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bbcw_pkg::item_t in_item,
  output bbcw_pkg::q_head_t head,
  input  logic            pop
);
  import bbcw_pkg::*;

  item_t      buf_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready   = (cnt_r != 2'(QDEPTH));
  assign push       = in_valid && in_ready;
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r].op  <= (in_item.op == OP_COMPUTE) ? OP_COMPUTE : OP_STORE;
      buf_r[wp_r].x   <= in_item.x;
      buf_r[wp_r].y   <= in_item.y;
      buf_r[wp_r].pix <= in_item.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

### src/bbcw_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit 8 bits.
module bbcw_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bbcw_pkg::NUM_W-1:0] num,
  input  logic [bbcw_pkg::DEN_W-1:0] den,
  output logic [bbcw_pkg::Q_W-1:0]   quo,
  output logic                      done
);
  import bbcw_pkg::*;

  logic [NUM_W-1:0] rem_r;
  logic [Q_W-1:0]   quo_r;
  logic [2:0]       bit_r;
  logic             busy_r, done_r;
  logic [NUM_W-1:0] den_sh;

  assign den_sh = NUM_W'(den) << bit_r;
  assign quo    = quo_r;
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      quo_r <= '0;
    end else if (busy_r && rem_r >= den_sh) begin
      rem_r        <= rem_r - den_sh;
      quo_r[bit_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= 3'd7;
    end else begin
      done_r <= !start && busy_r && (bit_r == 3'd0);
      if (start) begin
        busy_r <= 1'b1;
        bit_r  <= 3'd7;
      end else if (busy_r) begin
        bit_r <= bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end
endmodule

### src/bbcw_engine.sv
// Back end: frame store, window read sequencer, accumulators, dividers and result register.
module bbcw_engine #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_WINDOW = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bbcw_pkg::cfg_t              cfg,
  input  bbcw_pkg::q_head_t           head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bbcw_pkg::POS_W-1:0]  out_x,
  output logic [bbcw_pkg::POS_W-1:0]  out_y,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_red
);
  import bbcw_pkg::*;

  localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = XW + YW;
  localparam int WW = $clog2(MAX_WINDOW + 1);

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_DIV, S_DONE} state_t;

  state_t           state_r;
  logic [PIX_W-1:0] mem [2**AW];
  logic [PIX_W-1:0] rdata_r;
  logic             rd_v_r;
  logic [POS_W-1:0] px_r, py_r;
  logic [12:0]      iw_r, ih_r;
  logic [WW-1:0]    ww_r, wh_r, offx_r, offy_r, l_r, k_r;
  logic [DEN_W-1:0] den_r;
  logic [SUM_W-1:0] sb_r, sg_r, sr_r;
  logic             div_start_r;
  logic             out_valid_r;
  logic [POS_W-1:0] out_x_r, out_y_r;
  logic [7:0]       ob_r, og_r, or_r;

  logic [12:0]      iw_e, ih_e, ww_e, wh_e;
  logic             is_store, store_ok;
  logic [AW-1:0]    waddr, raddr;
  logic signed [CRD_W-1:0] sx, sy, cx, cy;
  logic             last;
  logic [Q_W-1:0]   qb, qg, qr;
  div_ctl_t         dctl;
  logic             dg_unused, dr_unused;

  function automatic logic [12:0] sat(input logic [12:0] v, input logic [12:0] hi);
    if (v == 13'd0) return 13'd1;
    if (v > hi)     return hi;
    return v;
  endfunction

  function automatic logic signed [CRD_W-1:0] clampc(input logic signed [CRD_W-1:0] v,
                                                     input logic [12:0] lim);
    logic signed [CRD_W-1:0] top;
    top = $signed({1'b0, lim}) - CRD_W'(1);
    if (v < 0)   return '0;
    if (v > top) return top;
    return v;
  endfunction

  assign iw_e = sat(13'(cfg.img_w), 13'(MAX_WIDTH));
  assign ih_e = sat(13'(cfg.img_h), 13'(MAX_HEIGHT));
  assign ww_e = sat(13'(cfg.win_w), 13'(MAX_WINDOW));
  assign wh_e = sat(13'(cfg.win_h), 13'(MAX_WINDOW));

  assign pop      = (state_r == S_IDLE) && head.valid;
  assign is_store = (head.item.op == OP_STORE);
  assign store_ok = (13'(head.item.x) < 13'(MAX_WIDTH)) && (13'(head.item.y) < 13'(MAX_HEIGHT));
  assign waddr    = {YW'(13'(head.item.y)), XW'(13'(head.item.x))};

  assign sx = $signed(CRD_W'(px_r)) - $signed(CRD_W'(offx_r)) + $signed(CRD_W'(l_r));
  assign sy = $signed(CRD_W'(py_r)) - $signed(CRD_W'(offy_r)) + $signed(CRD_W'(k_r));
  assign cx = clampc(sx, iw_r);
  assign cy = clampc(sy, ih_r);
  assign raddr = {YW'(13'(cy)), XW'(13'(cx))};
  assign last  = (l_r == ww_r - WW'(1)) && (k_r == wh_r - WW'(1));

  always_ff @(posedge clk) begin
    if (pop && is_store && store_ok) mem[waddr] <= head.item.pix;
    rdata_r <= mem[raddr];
  end

  assign dctl.start = div_start_r;

  bbcw_div u_div_b (.clk, .rst_n, .start(dctl.start),
    .num({sb_r, 1'b0} + NUM_W'(den_r >> 1)), .den(den_r), .quo(qb), .done(dctl.done));
  bbcw_div u_div_g (.clk, .rst_n, .start(dctl.start),
    .num({sg_r, 1'b0} + NUM_W'(den_r >> 1)), .den(den_r), .quo(qg), .done(dg_unused));
  bbcw_div u_div_r (.clk, .rst_n, .start(dctl.start),
    .num({sr_r, 1'b0} + NUM_W'(den_r >> 1)), .den(den_r), .quo(qr), .done(dr_unused));

  always_ff @(posedge clk) begin
    if (pop && !is_store) begin
      px_r   <= head.item.x;
      py_r   <= head.item.y;
      iw_r   <= iw_e;
      ih_r   <= ih_e;
      ww_r   <= WW'(ww_e);
      wh_r   <= WW'(wh_e);
      offx_r <= WW'((ww_e - 13'd1) >> 1);
      offy_r <= WW'((wh_e - 13'd1) >> 1);
      den_r  <= (ww_e * wh_e) << 1;
      sb_r   <= '0;
      sg_r   <= '0;
      sr_r   <= '0;
    end else if (rd_v_r) begin
      sb_r <= sb_r + SUM_W'(rdata_r[7:0]);
      sg_r <= sg_r + SUM_W'(rdata_r[15:8]);
      sr_r <= sr_r + SUM_W'(rdata_r[23:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      l_r         <= '0;
      k_r         <= '0;
    end else begin
      rd_v_r      <= (state_r == S_RUN);
      div_start_r <= (state_r == S_DRAIN);
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pop && !is_store) begin
            l_r     <= '0;
            k_r     <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (last) begin
            state_r <= S_DRAIN;
          end else if (l_r == ww_r - WW'(1)) begin
            l_r <= '0;
            k_r <= k_r + WW'(1);
          end else begin
            l_r <= l_r + WW'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (dctl.done) state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_x_r     <= px_r;
            out_y_r     <= py_r;
            ob_r        <= qb;
            og_r        <= qg;
            or_r        <= qr;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_blue  = ob_r;
  assign out_green = og_r;
  assign out_red   = or_r;
endmodule

### src/box_blur_clamped_window_unit.sv
// Box blur unit over a stored frame with edge-clamped window.
// Store request: accepted into a 2-entry queue, written to the frame store on its pop.
// Compute request: frame store reads of the ww*wh window pixels, then drain, divider start,
// 8-step divide, done and result load, which waits while a held result is not yet taken;
// the back end takes its next request only once it is back in idle.
// Reset (rst_n, synchronous): registers go to 512x512 image, 3x3 window; queue and
// result empty. Frame store contents are not cleared.
module box_blur_clamped_window_unit #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_WINDOW = 31
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [9:0]                 cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [bbcw_pkg::POS_W-1:0] in_pos_x,
  input  logic [bbcw_pkg::POS_W-1:0] in_pos_y,
  input  logic [7:0]                 in_blue,
  input  logic [7:0]                 in_green,
  input  logic [7:0]                 in_red,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bbcw_pkg::POS_W-1:0] out_x,
  output logic [bbcw_pkg::POS_W-1:0] out_y,
  output logic [7:0]                 out_blue,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_red
);
  import bbcw_pkg::*;

  cfg_t    cfg_r;
  item_t   in_item;
  q_head_t head;
  logic    pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.img_w <= 10'd512;
      cfg_r.img_h <= 10'd512;
      cfg_r.win_w <= 5'd3;
      cfg_r.win_h <= 5'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMG_W: cfg_r.img_w <= cfg_wdata;
        REG_IMG_H: cfg_r.img_h <= cfg_wdata;
        REG_WIN_W: cfg_r.win_w <= cfg_wdata[4:0];
        REG_WIN_H: cfg_r.win_h <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  assign in_item.op  = in_opcode;
  assign in_item.x   = in_pos_x;
  assign in_item.y   = in_pos_y;
  assign in_item.pix = {in_red, in_green, in_blue};

  bbcw_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_item, .head, .pop
  );

  bbcw_engine #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_WINDOW(MAX_WINDOW)
  ) u_engine (
    .clk, .rst_n, .cfg(cfg_r), .head, .pop,
    .out_valid, .out_ready, .out_x, .out_y, .out_blue, .out_green, .out_red
  );

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid) else $error("pop from empty queue");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_queue_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> head.valid) else $error("queue stalled while empty");
endmodule
